@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file of the tga rle decoder
// no dependencies; take in with an include of the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off while reset is low
`define TGARLE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tgarle assertion failed");

// next-cycle implication, sampled on the rising clock, off while reset is low
`define TGARLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tgarle assertion failed");

`endif

@@ rtl/tgarle_pkg.sv @@
// shared types and constants of the tga rle pixel decoder
// no dependencies; used by front, queue, back and top level by scoped names
package tgarle_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_COMPRESSED    = 2'd0;
  localparam logic [1:0] REG_ALPHA_PRESENT = 2'd1;
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd2;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd3;

  // position of the next byte inside a pixel
  localparam logic [1:0] POS_BLUE  = 2'd0;
  localparam logic [1:0] POS_GREEN = 2'd1;
  localparam logic [1:0] POS_RED   = 2'd2;
  localparam logic [1:0] POS_ALPHA = 2'd3;

  // packet header: top bit marks a run, run length is header minus bias
  localparam logic [7:0] RUN_BIAS = 8'd127;

  typedef struct packed {
    logic        compressed;
    logic        alpha_present;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic       last_of_image;
    logic [7:0] repeat_count;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  localparam int unsigned PIX_W = $bits(pix_t);

endpackage

@@ rtl/tgarle_fifo.sv @@
// short pixel queue between the byte front end and the output back end
// depends on tgarle_pkg for the pixel record type
module tgarle_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tgarle_pkg::pix_t  data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output tgarle_pkg::pix_t  data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tgarle_pkg::pix_t  mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/tgarle_front.sv @@
// byte front end: packet headers, pixel assembly, run and image counting
// depends on tgarle_pkg; feeds finished pixel records into tgarle_fifo
module tgarle_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tgarle_pkg::cfg_t  cfg_i,
  input  logic              restart_i,
  input  logic              byte_valid_i,
  input  logic [7:0]        byte_data_i,
  output logic              byte_ready_o,
  output logic              pix_valid_o,
  output tgarle_pkg::pix_t  pix_o,
  input  logic              pix_ready_i
);

  logic [1:0]  pos_q, pos_d;
  logic        header_due_q, header_due_d;
  logic        repeat_q, repeat_d;
  logic [7:0]  pkt_left_q, pkt_left_d;
  logic [7:0]  blue_q, blue_d;
  logic [7:0]  green_q, green_d;
  logic [7:0]  red_q, red_d;
  logic [31:0] img_left_q, img_left_d;

  logic        acc;
  logic        finish;
  logic [7:0]  alpha_byte;
  logic [15:0] w_eff, h_eff;
  logic [31:0] img_total;
  logic [7:0]  count_raw, count_nz, count_clip;
  logic [7:0]  pkt_dec, pkt_after;
  logic [31:0] img_after;

  assign acc          = byte_valid_i & pix_ready_i;
  assign byte_ready_o = pix_ready_i;

  // a zero dimension counts as one
  assign w_eff     = (cfg_i.image_width == '0) ? 16'd1 : cfg_i.image_width;
  assign h_eff     = (cfg_i.image_height == '0) ? 16'd1 : cfg_i.image_height;
  assign img_total = {16'b0, w_eff} * {16'b0, h_eff};

  // pixel completion arithmetic, valid whenever finish is set
  assign count_raw  = (cfg_i.compressed && repeat_q) ? pkt_left_q : 8'd1;
  assign count_nz   = (count_raw == '0) ? 8'd1 : count_raw;
  assign count_clip = ({24'b0, count_nz} > img_left_q) ? img_left_q[7:0] : count_nz;
  assign img_after  = img_left_q - {24'b0, count_clip};
  assign pkt_dec    = (pkt_left_q != '0) ? pkt_left_q - 8'd1 : 8'd0;
  assign pkt_after  = repeat_q ? 8'd0 : pkt_dec;

  always_comb begin
    pos_d        = pos_q;
    header_due_d = header_due_q;
    repeat_d     = repeat_q;
    pkt_left_d   = pkt_left_q;
    blue_d       = blue_q;
    green_d      = green_q;
    red_d        = red_q;
    img_left_d   = img_left_q;
    finish       = 1'b0;
    alpha_byte   = 8'd0;

    if (restart_i) begin
      pos_d        = tgarle_pkg::POS_BLUE;
      header_due_d = 1'b1;
      repeat_d     = 1'b0;
      pkt_left_d   = 8'd0;
      blue_d       = 8'd0;
      green_d      = 8'd0;
      red_d        = 8'd0;
      img_left_d   = 32'd0;
    end else if (acc) begin
      if (cfg_i.compressed && header_due_q) begin
        // packet header, also opens a new image when none is running
        if (img_left_q == '0) begin
          img_left_d = img_total;
        end
        repeat_d     = byte_data_i[7];
        pkt_left_d   = byte_data_i[7] ? byte_data_i - tgarle_pkg::RUN_BIAS
                                      : byte_data_i + 8'd1;
        header_due_d = 1'b0;
        pos_d        = tgarle_pkg::POS_BLUE;
      end else begin
        unique case (pos_q)
          tgarle_pkg::POS_BLUE: begin
            blue_d = byte_data_i;
            pos_d  = tgarle_pkg::POS_GREEN;
            if (!cfg_i.compressed && img_left_q == '0) begin
              img_left_d = img_total;
            end
          end
          tgarle_pkg::POS_GREEN: begin
            green_d = byte_data_i;
            pos_d   = tgarle_pkg::POS_RED;
          end
          tgarle_pkg::POS_RED: begin
            red_d = byte_data_i;
            if (cfg_i.alpha_present) begin
              pos_d = tgarle_pkg::POS_ALPHA;
            end else begin
              finish = 1'b1;
            end
          end
          tgarle_pkg::POS_ALPHA: begin
            alpha_byte = byte_data_i;
            finish     = 1'b1;
          end
        endcase

        if (finish) begin
          pos_d      = tgarle_pkg::POS_BLUE;
          img_left_d = img_after;
          if (cfg_i.compressed) begin
            pkt_left_d = pkt_after;
            if (pkt_after == '0) begin
              header_due_d = 1'b1;
            end
          end
          // image complete: drop what is left of the packet
          if (img_after == '0) begin
            header_due_d = 1'b1;
            pkt_left_d   = 8'd0;
            repeat_d     = 1'b0;
          end
        end
      end
    end
  end

  assign pix_valid_o         = acc & finish & ~restart_i;
  assign pix_o.red           = (pos_q == tgarle_pkg::POS_RED) ? byte_data_i : red_q;
  assign pix_o.green         = green_q;
  assign pix_o.blue          = blue_q;
  assign pix_o.alpha         = alpha_byte;
  assign pix_o.repeat_count  = count_clip;
  assign pix_o.last_of_image = (img_after == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= tgarle_pkg::POS_BLUE;
      header_due_q <= 1'b1;
      repeat_q     <= 1'b0;
      pkt_left_q   <= 8'd0;
      img_left_q   <= 32'd0;
      blue_q       <= 8'd0;
      green_q      <= 8'd0;
      red_q        <= 8'd0;
    end else begin
      pos_q        <= pos_d;
      header_due_q <= header_due_d;
      repeat_q     <= repeat_d;
      pkt_left_q   <= pkt_left_d;
      img_left_q   <= img_left_d;
      blue_q       <= blue_d;
      green_q      <= green_d;
      red_q        <= red_d;
    end
  end

endmodule

@@ rtl/tgarle_back.sv @@
// output back end: drains the pixel queue into the registered output stream
// depends on tgarle_pkg for the pixel record type
module tgarle_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pix_valid_i,
  input  tgarle_pkg::pix_t  pix_i,
  output logic              pop_o,
  output logic              out_valid_o,
  output logic [39:0]       out_data_o,
  output logic              out_last_o,
  input  logic              out_ready_i
);

  logic        valid_q, valid_d;
  logic [39:0] data_q;
  logic        last_q;
  logic        load;

  // refill the output register whenever it is empty or being taken
  assign load    = pix_valid_i & (~valid_q | out_ready_i);
  assign pop_o   = load;
  assign valid_d = load | (valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= {pix_i.repeat_count, pix_i.alpha, pix_i.blue, pix_i.green, pix_i.red};
      last_q <= pix_i.last_of_image;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;

endmodule

@@ rtl/tga_rle_pixel_decoder_core.sv @@
// top level of the tga rle pixel decoder: config registers and the three parts
// depends on tgarle_pkg, tgarle_front, tgarle_fifo and tgarle_back
//
// channel   direction  handshake                 payload
// s_axis    in         tvalid / tready           tdata[7:0] data_byte
// m_axis    out        tvalid / tready           tdata[39:0] pixel, tlast last_of_image
// apb       in         psel / penable / pready   paddr[3:2] register, pwdata / prdata
//
// one byte is taken every cycle while the pixel queue has room
// a pixel is queued as its last byte is taken, then registered for output on m_axis
// the front end keeps running while m_axis stalls until the queue fills
// reset clears control state; registers return to compressed, no alpha, 1 x 1
// any register write restarts the byte parser and the image count
module tga_rle_pixel_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // data_byte in bits 7:0
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // red 7:0, green 15:8, blue 23:16, alpha 31:24, repeat_count 39:32
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tgarle_pkg::cfg_t cfg_q, cfg_d;
  logic             wr_en;
  logic [1:0]       reg_idx;

  logic             f_pix_valid;
  tgarle_pkg::pix_t f_pix;
  logic             q_full, q_empty, q_pop;
  tgarle_pkg::pix_t q_pix;

  // ---------------------------------------------------------------------------
  // configuration port, no wait states
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        tgarle_pkg::REG_COMPRESSED:    cfg_d.compressed    = pwdata[0];
        tgarle_pkg::REG_ALPHA_PRESENT: cfg_d.alpha_present = pwdata[0];
        tgarle_pkg::REG_IMAGE_WIDTH:   cfg_d.image_width   = pwdata[15:0];
        tgarle_pkg::REG_IMAGE_HEIGHT:  cfg_d.image_height  = pwdata[15:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.compressed    <= 1'b1;
      cfg_q.alpha_present <= 1'b0;
      cfg_q.image_width   <= 16'd1;
      cfg_q.image_height  <= 16'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back, upper bits zero
  always_comb begin
    unique case (reg_idx)
      tgarle_pkg::REG_COMPRESSED:    prdata = {31'b0, cfg_q.compressed};
      tgarle_pkg::REG_ALPHA_PRESENT: prdata = {31'b0, cfg_q.alpha_present};
      tgarle_pkg::REG_IMAGE_WIDTH:   prdata = {16'b0, cfg_q.image_width};
      tgarle_pkg::REG_IMAGE_HEIGHT:  prdata = {16'b0, cfg_q.image_height};
    endcase
  end

  // ---------------------------------------------------------------------------
  // front end: parses bytes, counts runs and image pixels, builds records
  // ---------------------------------------------------------------------------
  tgarle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .restart_i    (wr_en),
    .byte_valid_i (s_axis_tvalid),
    .byte_data_i  (s_axis_tdata),
    .byte_ready_o (s_axis_tready),
    .pix_valid_o  (f_pix_valid),
    .pix_o        (f_pix),
    .pix_ready_i  (~q_full)
  );

  // short queue so the two sides stall independently
  tgarle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_pix_valid),
    .data_i  (f_pix),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_pix)
  );

  // back end: registered output stage on m_axis
  tgarle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (~q_empty),
    .pix_i       (q_pix),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

endmodule

@@ rtl/tgarle_checker.sv @@
// port-level checks on the tga rle pixel decoder, bound to the top level
// depends on assert_macros.svh and tga_rle_pixel_decoder_core
`include "assert_macros.svh"

module tgarle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        pwrite,
  input logic [31:0] prdata
);

  // a stalled pixel holds until taken
  `TGARLE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // a run is never empty and never longer than one packet
  `TGARLE_ASSERT_IMPL(a_count_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[39:32] != 8'd0 && m_axis_tdata[39:32] <= 8'd128)

  // no register is wider than sixteen bits
  `TGARLE_ASSERT_IMPL(a_rd_upper_zero, clk_i, rst_ni, psel && !pwrite, prdata[31:16] == 16'd0)

endmodule

bind tga_rle_pixel_decoder_core tgarle_checker u_tgarle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .psel          (psel),
  .pwrite        (pwrite),
  .prdata        (prdata)
);

@@ tb/sv/tgarle_pixel_check.sv @@
// pixel checker for the tga rle decoder: watches the apb, byte and pixel channels
// depends on tgarle_pkg; keeps its own decoder state and the queue of pixels due
`timescale 1ns / 100ps

module tgarle_pixel_check (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // data_byte in bits 7:0
  input  logic [7:0]            s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // red 7:0, green 15:8, blue 23:16, alpha 31:24, repeat_count 39:32
  input  logic [39:0]           m_axis_tdata,
  input  logic                  m_axis_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int unsigned           fails_o,
  output int unsigned           pending_o,
  output int unsigned           pixels_o,
  output int unsigned           image_ends_o
);

  tgarle_pkg::cfg_t cfg;

  logic [1:0]  byte_pos;
  logic        header_due;
  logic        run_packet;
  logic [7:0]  packet_left;
  logic [7:0]  held_blue;
  logic [7:0]  held_green;
  logic [7:0]  held_red;
  logic [31:0] image_left;

  tgarle_pkg::pix_t pixels_due[$];

  function automatic void restart_parser();
    byte_pos    = tgarle_pkg::POS_BLUE;
    header_due  = 1'b1;
    run_packet  = 1'b0;
    packet_left = 8'd0;
    held_blue   = 8'd0;
    held_green  = 8'd0;
    held_red    = 8'd0;
    image_left  = 32'd0;
  endfunction

  // a zero dimension counts as one
  function automatic void start_image();
    logic [31:0] w;
    logic [31:0] h;
    w = (cfg.image_width == 16'd0) ? 32'd1 : {16'd0, cfg.image_width};
    h = (cfg.image_height == 16'd0) ? 32'd1 : {16'd0, cfg.image_height};
    if (image_left == 32'd0) image_left = w * h;
  endfunction

  // one byte in, at most one pixel appended to the queue
  function automatic void decode_byte(input logic [7:0] b);
    logic [7:0]       alpha_byte;
    logic [31:0]      count;
    tgarle_pkg::pix_t px;
    alpha_byte = 8'd0;
    if (cfg.compressed && header_due) begin
      start_image();
      run_packet  = b[7];
      packet_left = run_packet ? (b - tgarle_pkg::RUN_BIAS) : (b + 8'd1);
      header_due  = 1'b0;
      byte_pos    = tgarle_pkg::POS_BLUE;
      return;
    end
    if (!cfg.compressed && byte_pos == tgarle_pkg::POS_BLUE) start_image();
    case (byte_pos)
      tgarle_pkg::POS_BLUE: begin
        held_blue = b;
        byte_pos  = tgarle_pkg::POS_GREEN;
        return;
      end
      tgarle_pkg::POS_GREEN: begin
        held_green = b;
        byte_pos   = tgarle_pkg::POS_RED;
        return;
      end
      tgarle_pkg::POS_RED: begin
        held_red = b;
        if (cfg.alpha_present) begin
          byte_pos = tgarle_pkg::POS_ALPHA;
          return;
        end
      end
      default: alpha_byte = b;
    endcase
    byte_pos = tgarle_pkg::POS_BLUE;

    if (cfg.compressed) begin
      count = run_packet ? {24'd0, packet_left} : 32'd1;
      if (run_packet) packet_left = 8'd0;
      else if (packet_left != 8'd0) packet_left = packet_left - 8'd1;
      if (packet_left == 8'd0) header_due = 1'b1;
    end else begin
      count = 32'd1;
    end
    if (count == 32'd0) count = 32'd1;
    // runs are clipped at the image end
    if (count > image_left) count = image_left;
    image_left = image_left - count;
    // image finished inside a packet: the rest of the packet is dropped
    if (image_left == 32'd0) begin
      header_due  = 1'b1;
      packet_left = 8'd0;
      run_packet  = 1'b0;
    end

    px.red           = held_red;
    px.green         = held_green;
    px.blue          = held_blue;
    px.alpha         = cfg.alpha_present ? alpha_byte : 8'd0;
    px.repeat_count  = count[7:0];
    px.last_of_image = (image_left == 32'd0);
    pixels_due.push_back(px);
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: pixel %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fails_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tgarle_pkg::pix_t want;
    if (!rst_ni) begin
      cfg.compressed    = 1'b1;
      cfg.alpha_present = 1'b0;
      cfg.image_width   = 16'd1;
      cfg.image_height  = 16'd1;
      restart_parser();
      pixels_due.delete();
      fails_o      = 0;
      pending_o    = 0;
      pixels_o     = 0;
      image_ends_o = 0;
    end else begin
      // any register write restarts the parser
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          tgarle_pkg::REG_COMPRESSED:    cfg.compressed    = pwdata[0];
          tgarle_pkg::REG_ALPHA_PRESENT: cfg.alpha_present = pwdata[0];
          tgarle_pkg::REG_IMAGE_WIDTH:   cfg.image_width   = pwdata[15:0];
          tgarle_pkg::REG_IMAGE_HEIGHT:  cfg.image_height  = pwdata[15:0];
        endcase
        restart_parser();
      end
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixels_due.size() == 0) begin
          $display("%0t ns: pixel with none expected, got data %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
          fails_o++;
        end else begin
          want = pixels_due.pop_front();
          check_field("red",    want.red,          m_axis_tdata[7:0]);
          check_field("green",  want.green,        m_axis_tdata[15:8]);
          check_field("blue",   want.blue,         m_axis_tdata[23:16]);
          check_field("alpha",  want.alpha,        m_axis_tdata[31:24]);
          check_field("repeat", want.repeat_count, m_axis_tdata[39:32]);
          check_field("last",   {7'd0, want.last_of_image}, {7'd0, m_axis_tlast});
          pixels_o++;
          if (m_axis_tlast) image_ends_o++;
        end
      end
      pending_o = pixels_due.size();
    end
  end

endmodule

@@ tb/sv/tga_rle_pixel_decoder_core_test.sv @@
// top of the tga rle decoder testbench: clock, reset, byte and register stimulus
// depends on tgarle_pkg, tga_rle_pixel_decoder_core and tgarle_pixel_check
`timescale 1ns / 100ps

module tga_rle_pixel_decoder_core_test;

  // generous bound, the slowest correct run stays far below it
  localparam int unsigned CYCLE_LIMIT = 200000;
  // cycles left after the last pixel so that a trailing header byte settles
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASES = 8;
  localparam int unsigned BYTES_PER_PHASE = 160;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fails;
  int unsigned pending;
  int unsigned pixels;
  int unsigned image_ends;

  // pacing knobs, percent of cycles spent idle or stalled
  int unsigned idle_pct;
  int unsigned stall_pct;
  // long receiver hold-off, counted down by the receiver process
  int unsigned hold_cycles;
  int unsigned cycles;
  int unsigned bytes_sent;
  int unsigned settings_seen;

  // local copy of the current register setting, used to shape packets
  logic        cur_compressed;
  logic        cur_alpha;
  int unsigned cur_w;
  int unsigned cur_h;

  tga_rle_pixel_decoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  tgarle_pixel_check pixel_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fails_o       (fails),
    .pending_o     (pending),
    .pixels_o      (pixels),
    .image_ends_o  (image_ends)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // watchdog on the cycle count
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d pixels outstanding", cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // pixel receiver: a pending hold-off wins, otherwise random stalls at stall_pct
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one byte, with random idle cycles ahead of it; returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // two-phase register write
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop offering, wait for every due pixel, then let the last header byte settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // writes all four registers, only ever from an idle decoder
  task automatic configure(input logic c, input logic a, input int unsigned w,
                           input int unsigned h);
    drain();
    write_reg(tgarle_pkg::REG_COMPRESSED,    {31'd0, c});
    write_reg(tgarle_pkg::REG_ALPHA_PRESENT, {31'd0, a});
    write_reg(tgarle_pkg::REG_IMAGE_WIDTH,   w);
    write_reg(tgarle_pkg::REG_IMAGE_HEIGHT,  h);
    cur_compressed = c;
    cur_alpha      = a;
    cur_w          = w & 32'hFFFF;
    cur_h          = h & 32'hFFFF;
    settings_seen++;
  endtask

  // mostly well-formed packets with random colours, a few stray bytes to break sync
  task automatic send_stream(input int unsigned budget);
    int unsigned left;
    int unsigned n;
    int unsigned k;
    int unsigned bpp;
    int unsigned start;
    int unsigned roll;
    logic [7:0]  hdr;
    bpp   = cur_alpha ? 4 : 3;
    left  = 0;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      if (left == 0) left = (cur_w == 0 ? 1 : cur_w) * (cur_h == 0 ? 1 : cur_h);
      roll = $urandom_range(99);
      if (roll < 6) begin
        send_byte(8'($urandom_range(255)));
      end else if (!cur_compressed) begin
        repeat (bpp) send_byte(8'($urandom_range(255)));
        left--;
      end else if (roll < 53) begin
        // run packet, now and then a long one
        hdr = 8'd128 + 8'(($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(7));
        send_byte(hdr);
        repeat (bpp) send_byte(8'($urandom_range(255)));
        n = hdr - 127;
        left = left - ((n < left) ? n : left);
      end else begin
        // raw packet, cut short where the image ends first
        hdr = 8'(($urandom_range(15) == 0) ? $urandom_range(127) : $urandom_range(3));
        send_byte(hdr);
        n = hdr + 1;
        k = (n < left) ? n : left;
        repeat (k * bpp) send_byte(8'($urandom_range(255)));
        left = left - k;
      end
    end
  endtask

  initial begin
    logic c;
    logic a;
    int unsigned w;
    int unsigned h;
    // every input known from time zero
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'd0;
    m_axis_tready  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = 4'd0;
    pwdata         = 32'd0;
    idle_pct       = 0;
    stall_pct      = 0;
    hold_cycles    = 0;
    bytes_sent     = 0;
    settings_seen  = 1;
    cur_compressed = 1'b1;
    cur_alpha      = 1'b0;
    cur_w          = 1;
    cur_h          = 1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, on the reset setting (compressed, no alpha, 1 x 1)
    // single-pixel run, then the longest run clipped to one pixel, then a raw packet
    send_byte(8'h80); send_byte(8'h01); send_byte(8'h02); send_byte(8'h03);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);

    // zero width counts as one: 1 x 2 image with alpha
    // a raw packet of six ends early at the image end, the next byte is a new header
    configure(1'b1, 1'b1, 0, 2);
    send_byte(8'h05);
    send_byte(8'h10); send_byte(8'h20); send_byte(8'h30); send_byte(8'h40);
    send_byte(8'h50); send_byte(8'h60); send_byte(8'h70); send_byte(8'h80);
    // run of two fills the next image exactly
    send_byte(8'h81);
    send_byte(8'hFF); send_byte(8'hFE); send_byte(8'hFD); send_byte(8'hFC);

    // random phases, pacing rotates through none, sender idle, receiver stall, both
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin c = 1'b1; a = 1'b0; w = 65535; h = 65535; end
        1: begin c = 1'b0; a = 1'b1; w = 1;     h = 1;     end
        2: begin c = 1'b1; a = 1'b1; w = 3;     h = 5;     end
        3: begin c = 1'b0; a = 1'b0; w = 0;     h = 0;     end
        4: begin c = 1'b1; a = 1'b0; w = 1;     h = 65535; end
        default: begin
          c = 1'($urandom_range(1));
          a = 1'($urandom_range(1));
          w = $urandom_range(6);
          h = $urandom_range(1, 6);
        end
      endcase
      configure(c, a, w, h);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      // long hold-off while bytes keep coming, so the pixel queue fills and input stalls
      if (ph == 4) hold_cycles = 300;
      send_stream(BYTES_PER_PHASE);
    end

    drain();
    $display("sent %0d bytes over %0d register settings; %0d pixels checked, %0d image ends",
             bytes_sent, settings_seen, pixels, image_ends);
    if (fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d pixels never arrived", fails, pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
